// ===== hw/rtl/ffha_pkg.sv =====
`timescale 1ns / 1ps
// ffha_pkg: shared types and constants of the first-fit heap allocator
// no dependencies

package ffha_pkg;

   // width of partition offsets and sizes (heap is at most 65536 bytes)
   localparam int EW = 17;

   // result status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_BADFREE = 2'd2;

   // request mode codes
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // smallest usable heap and rounding granule
   localparam int HEAP_MIN = 64;
   localparam int GRAIN    = 4;

   typedef struct packed {
      logic        mode;
      logic [15:0] request_size;
      logic [15:0] free_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] payload_offset;
   } rsp_type;

   // one partition table entry
   typedef struct packed {
      logic [EW-1:0] start;
      logic [EW-1:0] bytes;
      logic          busy;
   } entry_type;

endpackage

// ===== hw/rtl/first_fit_heap_allocator.sv =====
`timescale 1ns / 1ps
// Allocate or free one heap block per request beat against an address-ordered
// partition table held in a single-port-read memory. A request walks the table
// one entry per cycle through the registered read port; a success then updates
// the table, moving entries when a split inserts or a merge removes table
// entries. The scan and the moves together never pass part_count entries.
// req_ready is low from the accepted beat until its result is handed to the
// output register, and stays low while a finished result waits for it.
// After reset or a heap_size write the table is rebuilt in the S_INIT state.
// Depends on ffha_pkg, ffha_table and ffha_alu.

module first_fit_heap_allocator #(
   parameter int META_BYTES = 16,
   parameter int MAX_PARTS  = 64,
   parameter int HEAP_BYTES = 65536
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ffha_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ffha_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [16:0]       csr_wdata
);
   import ffha_pkg::*;

   localparam int AW   = $clog2(MAX_PARTS);
   localparam int CW   = $clog2(MAX_PARTS + 1);
   localparam int HMAX = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;

   localparam logic [EW-1:0] META_C  = EW'(META_BYTES);
   localparam logic [EW-1:0] HMAX_C  = EW'(HMAX);
   localparam logic [EW-1:0] HMIN_C  = EW'(HEAP_MIN);
   localparam logic [EW-1:0] GRAIN_C = EW'(GRAIN);
   localparam logic [CW-1:0] MAXP_C  = CW'(MAX_PARTS);

   typedef enum logic [17:0] {
      S_INIT = 18'h00001,
      S_IDLE = 18'h00002,
      S_SCAN = 18'h00004,
      S_ACHK = 18'h00008,
      S_APAY = 18'h00010,
      S_SHUP = 18'h00020,
      S_ANS  = 18'h00040,
      S_ANB  = 18'h00080,
      S_AWR  = 18'h00100,
      S_FRDN = 18'h00200,
      S_FRDP = 18'h00400,
      S_FMN  = 18'h00800,
      S_FMN2 = 18'h01000,
      S_FMP  = 18'h02000,
      S_FMP2 = 18'h04000,
      S_FWR  = 18'h08000,
      S_SHDN = 18'h10000,
      S_RESP = 18'h20000
   } state_type;

   state_type     state_ff, state_in;
   logic [16:0]   heap_ff, heap_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] chk_ff, chk_in;
   logic          pend_ff, pend_in;
   logic [CW-1:0] hit_ff, hit_in;
   logic          mode_ff, mode_in;
   logic [EW-1:0] want_ff, want_in;
   logic [EW-1:0] wm_ff, wm_in;
   logic [EW-1:0] need_ff, need_in;
   logic [EW-1:0] tgt_ff, tgt_in;
   logic          tgt_ok_ff, tgt_ok_in;
   entry_type     cur_ff, cur_in;
   entry_type     nxt_ff, nxt_in;
   entry_type     prv_ff, prv_in;
   logic          nxt_ok_ff, nxt_ok_in;
   logic          prv_ok_ff, prv_ok_in;
   logic [EW-1:0] tmp_ff, tmp_in;
   logic          split_ff, split_in;
   logic [1:0]    rm_n_ff, rm_n_in;
   logic [1:0]    status_ff, status_in;
   logic [15:0]   payload_ff, payload_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   // memory and shared unit hookup
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   entry_type     wr_data, rd_q;
   logic [EW-1:0] alu_a, alu_b;
   logic          alu_sub, alu_ge, alu_eq;
   logic [EW:0]   alu_res;

   logic [EW-1:0] req_ext, rounded, heap_clamp, heap_eff, first_bytes;
   logic          issue, hit, nfree, pfree;
   logic [CW-1:0] hit_p1, rm_dst;

   ffha_table #(
      .DEPTH (MAX_PARTS),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_q)
   );

   ffha_alu u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .op_sub (alu_sub),
      .res    (alu_res),
      .ge     (alu_ge),
      .eq     (alu_eq)
   );

   // request size rounded up to the granule, zero becomes one granule
   assign req_ext = {1'b0, req_data.request_size};
   assign rounded = (req_ext + EW'(GRAIN - 1)) & ~EW'(GRAIN - 1);

   // usable heap and payload of the single partition after a clear
   always_comb begin
      heap_clamp  = (heap_ff > HMAX_C) ? HMAX_C : heap_ff;
      heap_eff    = (heap_clamp < HMIN_C) ? HMIN_C : heap_clamp;
      first_bytes = (heap_eff > META_C) ? heap_eff - META_C : '0;
   end

   assign nfree  = nxt_ok_ff & ~nxt_ff.busy;
   assign pfree  = prv_ok_ff & ~prv_ff.busy;
   assign hit_p1 = hit_ff + CW'(1);
   assign rm_dst = pfree ? hit_ff : hit_p1;

   // operand select of the shared unit
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      case (state_ff)
         S_SCAN: begin
            alu_a   = (mode_ff == MODE_FREE) ? rd_q.start : rd_q.bytes;
            alu_b   = (mode_ff == MODE_FREE) ? tgt_ff : want_ff;
            alu_sub = 1'b1;
         end
         S_ACHK: begin
            alu_a   = cur_ff.bytes;
            alu_b   = need_ff;
            alu_sub = 1'b1;
         end
         S_APAY: begin
            alu_a = cur_ff.start;
            alu_b = META_C;
         end
         S_ANS: begin
            alu_a = cur_ff.start;
            alu_b = wm_ff;
         end
         S_ANB: begin
            alu_a   = cur_ff.bytes;
            alu_b   = wm_ff;
            alu_sub = 1'b1;
         end
         S_FMN: begin
            alu_a = cur_ff.bytes;
            alu_b = nxt_ff.bytes;
         end
         S_FMP: begin
            alu_a = prv_ff.bytes;
            alu_b = cur_ff.bytes;
         end
         S_FMN2, S_FMP2: begin
            alu_a = tmp_ff;
            alu_b = META_C;
         end
         default: begin
            alu_sub = 1'b0;
         end
      endcase
   end

   // scan hit test on the entry returned by the read port
   always_comb begin
      if (mode_ff == MODE_FREE) begin
         hit = pend_ff & rd_q.busy & tgt_ok_ff & alu_eq;
      end else begin
         hit = pend_ff & ~rd_q.busy & alu_ge;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      heap_in      = heap_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      chk_in       = chk_ff;
      pend_in      = 1'b0;
      hit_in       = hit_ff;
      mode_in      = mode_ff;
      want_in      = want_ff;
      wm_in        = wm_ff;
      need_in      = need_ff;
      tgt_in       = tgt_ff;
      tgt_ok_in    = tgt_ok_ff;
      cur_in       = cur_ff;
      nxt_in       = nxt_ff;
      prv_in       = prv_ff;
      nxt_ok_in    = nxt_ok_ff;
      prv_ok_in    = prv_ok_ff;
      tmp_in       = tmp_ff;
      split_in     = split_ff;
      rm_n_in      = rm_n_ff;
      status_in    = status_ff;
      payload_in   = payload_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      issue        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = cur_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;

      case (state_ff)
         // rebuild the table as one free partition
         S_INIT: begin
            wr_en         = 1'b1;
            wr_addr       = '0;
            wr_data.start = '0;
            wr_data.bytes = first_bytes;
            wr_data.busy  = 1'b0;
            count_in      = CW'(1);
            state_in      = S_IDLE;
         end

         // take a request beat
         S_IDLE: begin
            if (req_valid) begin
               mode_in   = req_data.mode;
               want_in   = (req_data.request_size == '0) ? GRAIN_C : rounded;
               wm_in     = ((req_data.request_size == '0) ? GRAIN_C : rounded) + META_C;
               need_in   = ((req_data.request_size == '0) ? GRAIN_C : rounded)
                           + META_C + GRAIN_C;
               tgt_in    = {1'b0, req_data.free_offset} - META_C;
               tgt_ok_in = ({1'b0, req_data.free_offset} >= META_C);
               ptr_in    = '0;
               state_in  = S_SCAN;
            end
         end

         // walk the table, one read issued and one entry checked per cycle
         S_SCAN: begin
            issue   = (ptr_ff < count_ff);
            rd_en   = issue;
            rd_addr = ptr_ff[AW-1:0];
            if (hit) begin
               hit_in   = chk_ff;
               cur_in   = rd_q;
               state_in = (mode_ff == MODE_FREE) ? S_FRDN : S_ACHK;
            end else if (!issue && !pend_ff) begin
               status_in  = (mode_ff == MODE_FREE) ? ST_BADFREE : ST_FULL;
               payload_in = '0;
               state_in   = S_RESP;
            end else begin
               pend_in = issue;
               chk_in  = ptr_ff;
               if (issue) begin
                  ptr_in = ptr_ff + CW'(1);
               end
            end
         end

         // split when a header plus one granule would remain and the table has room
         S_ACHK: begin
            split_in = alu_ge & (count_ff < MAXP_C);
            state_in = S_APAY;
         end

         S_APAY: begin
            payload_in = alu_res[15:0];
            status_in  = ST_OK;
            ptr_in     = count_ff - CW'(1);
            state_in   = split_ff ? S_SHUP : S_AWR;
         end

         // move entries above the hit up by one
         S_SHUP: begin
            issue   = (ptr_ff > hit_ff);
            rd_en   = issue;
            rd_addr = ptr_ff[AW-1:0];
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = chk_ff[AW-1:0];
               wr_data = rd_q;
            end
            if (issue) begin
               pend_in = 1'b1;
               chk_in  = ptr_ff + CW'(1);
               ptr_in  = ptr_ff - CW'(1);
            end else if (!pend_ff) begin
               state_in = S_ANS;
            end
         end

         S_ANS: begin
            tmp_in   = alu_res[EW-1:0];
            state_in = S_ANB;
         end

         // new free remainder after the hit
         S_ANB: begin
            wr_en         = 1'b1;
            wr_addr       = hit_p1[AW-1:0];
            wr_data.start = tmp_ff;
            wr_data.bytes = alu_res[EW-1:0];
            wr_data.busy  = 1'b0;
            count_in      = count_ff + CW'(1);
            state_in      = S_AWR;
         end

         S_AWR: begin
            wr_en         = 1'b1;
            wr_addr       = hit_ff[AW-1:0];
            wr_data.start = cur_ff.start;
            wr_data.bytes = split_ff ? want_ff : cur_ff.bytes;
            wr_data.busy  = 1'b1;
            state_in      = S_RESP;
         end

         // fetch neighbors of the freed entry
         S_FRDN: begin
            nxt_ok_in = (hit_p1 < count_ff);
            rd_en     = (hit_p1 < count_ff);
            rd_addr   = hit_p1[AW-1:0];
            state_in  = S_FRDP;
         end

         S_FRDP: begin
            nxt_in    = rd_q;
            prv_ok_in = (hit_ff != '0);
            rd_en     = (hit_ff != '0);
            rd_addr   = AW'(hit_ff - CW'(1));
            state_in  = S_FMN;
         end

         S_FMN: begin
            prv_in   = rd_q;
            tmp_in   = alu_res[EW-1:0];
            state_in = S_FMN2;
         end

         S_FMN2: begin
            if (nfree) begin
               cur_in.bytes = alu_res[EW-1:0];
            end
            state_in = S_FMP;
         end

         S_FMP: begin
            tmp_in   = alu_res[EW-1:0];
            state_in = S_FMP2;
         end

         S_FMP2: begin
            if (pfree) begin
               prv_in.bytes = alu_res[EW-1:0];
            end
            state_in = S_FWR;
         end

         // write the merged entry, then close the gap
         S_FWR: begin
            wr_en = 1'b1;
            if (pfree) begin
               wr_addr       = AW'(hit_ff - CW'(1));
               wr_data       = prv_ff;
               wr_data.busy  = 1'b0;
               rm_n_in       = 2'd1 + {1'b0, nfree};
            end else begin
               wr_addr       = hit_ff[AW-1:0];
               wr_data       = cur_ff;
               wr_data.busy  = 1'b0;
               rm_n_in       = {1'b0, nfree};
            end
            ptr_in    = rm_dst + CW'(pfree) + CW'(nfree);
            status_in  = ST_OK;
            payload_in = '0;
            state_in   = S_SHDN;
         end

         // move entries down over the removed ones
         S_SHDN: begin
            issue   = (ptr_ff < count_ff);
            rd_en   = issue;
            rd_addr = ptr_ff[AW-1:0];
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = chk_ff[AW-1:0];
               wr_data = rd_q;
            end
            if (issue) begin
               pend_in = 1'b1;
               chk_in  = ptr_ff - CW'(rm_n_ff);
               ptr_in  = ptr_ff + CW'(1);
            end else if (!pend_ff) begin
               count_in = count_ff - CW'(rm_n_ff);
               state_in = S_RESP;
            end
         end

         // hand the result to the output register
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.status         = status_ff;
               rsp_data_in.payload_offset = payload_ff;
               state_in                   = S_IDLE;
            end
         end

         default: begin
            state_in = S_INIT;
         end
      endcase

      // heap size write rebuilds the table
      if (csr_we) begin
         heap_in  = csr_wdata;
         state_in = S_INIT;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         heap_ff      <= 17'h10000;
         count_ff     <= CW'(1);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         heap_ff      <= heap_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      chk_ff      <= chk_in;
      hit_ff      <= hit_in;
      mode_ff     <= mode_in;
      want_ff     <= want_in;
      wm_ff       <= wm_in;
      need_ff     <= need_in;
      tgt_ff      <= tgt_in;
      tgt_ok_ff   <= tgt_ok_in;
      cur_ff      <= cur_in;
      nxt_ff      <= nxt_in;
      prv_ff      <= prv_in;
      nxt_ok_ff   <= nxt_ok_in;
      prv_ok_ff   <= prv_ok_in;
      tmp_ff      <= tmp_in;
      split_ff    <= split_in;
      rm_n_ff     <= rm_n_in;
      status_ff   <= status_in;
      payload_ff  <= payload_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/ffha_table.sv =====
`timescale 1ns / 1ps
// ffha_table: partition table memory, one write and one registered read port
// depends on ffha_pkg

module ffha_table #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  ffha_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output ffha_pkg::entry_type rd_data
);
   import ffha_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ffha_alu.sv =====
`timescale 1ns / 1ps
// ffha_alu: shared add / subtract-compare unit of the allocator sequencer
// depends on ffha_pkg

module ffha_alu (
   input  logic [ffha_pkg::EW-1:0] op_a,
   input  logic [ffha_pkg::EW-1:0] op_b,
   input  logic                    op_sub,
   output logic [ffha_pkg::EW:0]   res,
   output logic                    ge,
   output logic                    eq
);
   import ffha_pkg::*;

   logic [EW+1:0] full;

   // one extra bit catches the borrow of a subtract
   always_comb begin
      if (op_sub) begin
         full = {2'b00, op_a} - {2'b00, op_b};
      end else begin
         full = {2'b00, op_a} + {2'b00, op_b};
      end
   end

   assign res = full[EW:0];
   assign ge  = ~full[EW+1];
   assign eq  = (full == '0);

endmodule

// ===== hw/rtl/ffha_checker.sv =====
`timescale 1ns / 1ps
// ffha_checker: port-level assertions for first_fit_heap_allocator
// depends on ffha_pkg; bound to the top level below

module ffha_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ffha_pkg::rsp_type rsp_data,
   input logic              csr_we
);
   import ffha_pkg::*;

   // a result beat holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat dropped or changed while stalled");

   // a request beat starts a multi-cycle walk
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !csr_we |=> !req_ready)
      else $error("request accepted while previous walk in flight");

   // only defined status codes appear
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == ST_OK || rsp_data.status == ST_FULL ||
                     rsp_data.status == ST_BADFREE))
      else $error("undefined status code");

   // failures carry a zero offset
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.payload_offset == '0)
      else $error("failed request returned a nonzero offset");

   // a heap size write holds off requests while the table rebuilds
   a_cfg_rebuild: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_ready)
      else $error("request side ready during table rebuild");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_we    (csr_we)
);

// ===== tb/first_fit_heap_allocator_tb.sv =====
`timescale 1ns / 1ps
// first_fit_heap_allocator_tb: self-checking bench for the first-fit heap allocator
// keeps its own partition table, predicts each response beat and compares in order
// depends on ffha_pkg and first_fit_heap_allocator

module first_fit_heap_allocator_tb;
   import ffha_pkg::*;

   localparam int META = 16;
   localparam int PARTS = 64;
   localparam int HEAP_MAX = 65536;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [16:0] csr_wdata = '0;

   // predicted partition table
   int unsigned tbl_start [PARTS];
   int unsigned tbl_bytes [PARTS];
   bit          tbl_busy [PARTS];
   int unsigned tbl_count;
   int unsigned heap_cfg;

   rsp_type     pending_rsp [$];
   int unsigned live_offsets [$];
   int          errors = 0;
   int          rsp_idle_pct = 29;
   int          req_idle_pct = 29;
   bit          hold_rsp = 1'b0;

   first_fit_heap_allocator #(
      .META_BYTES(META),
      .MAX_PARTS(PARTS),
      .HEAP_BYTES(HEAP_MAX)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // rebuild the table as after reset or a heap size write
   function automatic void clear_partitions();
      int unsigned h;
      h = heap_cfg;
      if (h > HEAP_MAX) h = HEAP_MAX;
      if (h > 65536) h = 65536;
      if (h < HEAP_MIN) h = HEAP_MIN;
      for (int i = 0; i < PARTS; i++) begin
         tbl_start[i] = 0;
         tbl_bytes[i] = 0;
         tbl_busy[i] = 1'b0;
      end
      tbl_bytes[0] = (h > META) ? h - META : 0;
      tbl_count = 1;
      live_offsets.delete();
   endfunction

   function automatic void drop_entry(int unsigned k);
      for (int unsigned i = k; i + 1 < tbl_count; i++) begin
         tbl_start[i] = tbl_start[i + 1];
         tbl_bytes[i] = tbl_bytes[i + 1];
         tbl_busy[i] = tbl_busy[i + 1];
      end
      tbl_count--;
   endfunction

   // compute the response of one request and update the table
   function automatic rsp_type heap_request(req_type r);
      rsp_type     res;
      int unsigned want, i;
      res = '0;
      if (r.mode == MODE_ALLOC) begin
         want = (r.request_size == 0) ? GRAIN : ((r.request_size + 3) & ~32'd3);
         for (i = 0; i < tbl_count; i++)
            if (!tbl_busy[i] && tbl_bytes[i] >= want) break;
         if (i >= tbl_count) begin
            res.status = ST_FULL;
         end else begin
            if (tbl_bytes[i] >= want + META + GRAIN && tbl_count < PARTS) begin
               for (int unsigned j = tbl_count; j > i + 1; j--) begin
                  tbl_start[j] = tbl_start[j - 1];
                  tbl_bytes[j] = tbl_bytes[j - 1];
                  tbl_busy[j] = tbl_busy[j - 1];
               end
               tbl_start[i + 1] = tbl_start[i] + META + want;
               tbl_bytes[i + 1] = tbl_bytes[i] - META - want;
               tbl_busy[i + 1] = 1'b0;
               tbl_count++;
               tbl_bytes[i] = want;
            end
            tbl_busy[i] = 1'b1;
            res.status = ST_OK;
            res.payload_offset = 16'(tbl_start[i] + META);
            live_offsets.push_back(tbl_start[i] + META);
         end
      end else begin
         for (i = 0; i < tbl_count; i++)
            if (tbl_busy[i] && tbl_start[i] + META == r.free_offset) break;
         if (i >= tbl_count) begin
            res.status = ST_BADFREE;
         end else begin
            tbl_busy[i] = 1'b0;
            foreach (live_offsets[k])
               if (live_offsets[k] == r.free_offset) begin
                  live_offsets.delete(k);
                  break;
               end
            // merge runs of free neighbors
            for (int unsigned m = 0; m < tbl_count; m++)
               while (!tbl_busy[m] && m + 1 < tbl_count && !tbl_busy[m + 1]) begin
                  tbl_bytes[m] += tbl_bytes[m + 1] + META;
                  drop_entry(m + 1);
               end
         end
      end
      return res;
   endfunction

   // offer one request beat and hold it until accepted
   task automatic send_request(logic mode, int unsigned size, int unsigned offset);
      req_type r;
      r.mode = mode;
      r.request_size = 16'(size);
      r.free_offset = 16'(offset);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rsp.push_back(heap_request(r));
   endtask

   task automatic send_alloc(int unsigned size);
      send_request(MODE_ALLOC, size, $urandom_range(65535));
   endtask

   task automatic send_free(int unsigned offset);
      send_request(MODE_FREE, $urandom_range(65535), offset);
   endtask

   // wait until every response is in, then let the block settle
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (2 * PARTS + 20) @(negedge clock);
   endtask

   task automatic write_heap_size(int unsigned value);
      drain();
      csr_wdata <= 17'(value);
      csr_we <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      heap_cfg = value & 32'h1FFFF;
      clear_partitions();
      repeat (2) @(negedge clock);
   endtask

   // response ready with random stalls, or held off on request
   always @(negedge clock) begin
      if (reset || hold_rsp) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // check each response beat against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected beat, actual status %0d offset %0d",
                     $time, rsp_data.status, rsp_data.payload_offset);
            errors++;
         end else begin
            rsp_type exp_rsp;
            exp_rsp = pending_rsp.pop_front();
            if (rsp_data.status !== exp_rsp.status)
               begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           exp_rsp.status, rsp_data.status);
                  errors++;
               end
            if (rsp_data.payload_offset !== exp_rsp.payload_offset) begin
               $display("%0t: payload_offset expected %0d actual %0d", $time,
                        exp_rsp.payload_offset, rsp_data.payload_offset);
               errors++;
            end
         end
      end
   end

   // extremes of sizes, bad frees, full heap and the smallest heap
   task automatic test_directed();
      send_alloc(0);
      send_alloc(1);
      send_alloc(65535);
      send_alloc(7);
      send_free(16);
      send_free(16);
      send_free(0);
      send_free(65535);
      send_alloc(8);
      send_free(live_offsets[0]);
      write_heap_size(0);
      send_alloc(48);
      send_alloc(4);
      send_free(16);
      write_heap_size(17'h1FFFF);
      send_alloc(65535);
      send_alloc(65504);
      send_alloc(12);
      send_free(16);
      write_heap_size(64);
      send_alloc(28);
      send_alloc(24);
      send_free(16);
   endtask

   // fill the table past its entry limit so the split gets skipped
   task automatic test_table_full();
      write_heap_size(4096);
      for (int i = 0; i < PARTS + 4; i++) send_alloc($urandom_range(1, 40));
      while (live_offsets.size() > 0)
         send_free(live_offsets[$urandom_range(live_offsets.size() - 1)]);
   endtask

   // random alloc and free mix with mostly valid frees
   task automatic test_random(int n, int unsigned heap);
      int unsigned pick;
      write_heap_size(heap);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 45) send_alloc($urandom_range(0, 300));
         else if (pick < 50) send_alloc($urandom_range(65535));
         else if (pick < 90 && live_offsets.size() > 0)
            send_free(live_offsets[$urandom_range(live_offsets.size() - 1)]);
         else send_free($urandom_range(65535));
      end
   endtask

   // response side stalls while requests keep coming, then sender waits
   task automatic test_backpressure();
      hold_rsp = 1'b1;
      fork
         repeat (1500) @(negedge clock);
         for (int i = 0; i < 12; i++) send_alloc($urandom_range(0, 64));
      join_any
      hold_rsp = 1'b0;
      wait fork;
      drain();
      for (int i = 0; i < 8; i++) send_free(live_offsets[0]);
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      heap_cfg = 65536;
      clear_partitions();
      repeat (2) @(negedge clock);
      test_directed();
      test_table_full();
      test_backpressure();
      test_random(700, 2048);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random(300, 65535);
      req_idle_pct = 29;
      rsp_idle_pct = 29;
      test_random(700, $urandom_range(64, 65536));
      test_random(200, 512);
      drain();
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   initial begin
      #50ms;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_table.sv
hw/rtl/ffha_alu.sv
hw/rtl/first_fit_heap_allocator.sv
hw/rtl/ffha_checker.sv
tb/first_fit_heap_allocator_tb.sv
